>>> design/fct_pkg.sv
// Shared types, widths and arithmetic helpers for the friction-compensated torque command.
package fct_pkg;

	localparam int JOINT_W     = 3;
	localparam int ORDER_W     = 2;
	localparam int COEF_W      = 32;
	localparam int DRIVE_VEL_W = 32;
	localparam int TARGET_W    = 32;
	localparam int SCALE_W     = 24;
	localparam int CMD_OUT_W   = 16;
	localparam int CFG_W       = 20;
	localparam int CFG_IDX_W   = 2;

	localparam int TERM_COUNT  = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// clamped velocity: magnitude below 2^20, plus sign
	localparam int VEL_W  = CFG_W + 1;
	// polynomial term: clamped to +-2^40
	localparam int P_W    = 2 * VEL_W;
	localparam int LO_W   = 2 * VEL_W + 1;
	localparam int HI_W   = 2 * VEL_W;
	localparam int FULL_W = 3 * VEL_W;
	localparam int STEP_SHIFT  = 12;
	localparam int CLAMP_SHIFT = 40;

	localparam int FRIC_W    = P_W + 1;
	localparam int PRODT_W   = TARGET_W + SCALE_W + 1;
	localparam int FRIC_SHIFT = 16;
	localparam int TOT_W     = FRIC_W + FRIC_SHIFT + 1;
	localparam int CMD_SHIFT = 32;
	localparam int CMD_W     = TOT_W - CMD_SHIFT;

	localparam logic signed [FULL_W-1:0] TERM_LIMIT = FULL_W'(64'd1 << CLAMP_SHIFT);
	localparam logic signed [FULL_W-1:0] STEP_BIAS  = FULL_W'((64'd1 << STEP_SHIFT) - 64'd1);
	localparam logic signed [TOT_W-1:0]  CMD_BIAS   = TOT_W'((64'd1 << CMD_SHIFT) - 64'd1);
	localparam logic signed [CMD_OUT_W-1:0] CMD_MAX = 16'sh7FFF;
	localparam logic signed [CMD_OUT_W-1:0] CMD_MIN = 16'sh8000;

	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd1;

	localparam logic [CFG_W-1:0] DEADBAND_RESET = 20'd100;
	localparam logic [CFG_W-1:0] LIMIT_RESET    = 20'd1000000;

	typedef struct packed {
		logic [CFG_W-1:0] deadband;
		logic [CFG_W-1:0] limit;
	} cfg_t;

	typedef struct packed {
		logic                       is_load;
		logic [JOINT_W-1:0]         joint;
		logic                       side;
		logic [ORDER_W-1:0]         order;
		logic [COEF_W-1:0]          coef;
		logic                       active;
		logic signed [VEL_W-1:0]    vel;
		logic signed [TARGET_W-1:0] target;
		logic [SCALE_W-1:0]         scale;
		logic                       negate;
	} queue_entry_t;

	// p * v split as (p_hi * 2^21 + p_lo) * v; low partial product
	function automatic logic signed [LO_W-1:0] step_lo(input logic signed [P_W-1:0] p,
			input logic signed [VEL_W-1:0] v);
		logic signed [VEL_W:0] pl;
		pl = $signed({1'b0, p[VEL_W-1:0]});
		return LO_W'(pl) * LO_W'(v);
	endfunction

	function automatic logic signed [HI_W-1:0] step_hi(input logic signed [P_W-1:0] p,
			input logic signed [VEL_W-1:0] v);
		logic signed [VEL_W-1:0] ph;
		ph = $signed(p[P_W-1:VEL_W]);
		return HI_W'(ph) * HI_W'(v);
	endfunction

	// join partials, shift right truncating toward zero, clamp to +-2^40
	function automatic logic signed [P_W-1:0] step_join(input logic signed [HI_W-1:0] hi,
			input logic signed [LO_W-1:0] lo);
		logic signed [FULL_W-1:0] full;
		logic signed [FULL_W-1:0] q;
		full = (FULL_W'(hi) <<< VEL_W) + FULL_W'(lo);
		q = full + ((full < 0) ? STEP_BIAS : '0);
		q = q >>> STEP_SHIFT;
		if (q > TERM_LIMIT) begin
			return P_W'(TERM_LIMIT);
		end else if (q < -TERM_LIMIT) begin
			return P_W'(-TERM_LIMIT);
		end
		return P_W'(q);
	endfunction

endpackage

>>> design/fct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fct_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 12
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/fct_front.sv
// Request intake: joint range check, deadband test, velocity clamp and side select.
module fct_front #(
	parameter int JOINT_COUNT = 6
) (
	input  logic                                  start,
	input  logic                                  busy,
	input  fct_pkg::cfg_t                         cfg,
	input  logic                                  mode,
	input  logic [fct_pkg::JOINT_W-1:0]           joint_index,
	input  logic                                  negative_side,
	input  logic [fct_pkg::ORDER_W-1:0]           power_order,
	input  logic signed [fct_pkg::COEF_W-1:0]     coefficient_value,
	input  logic signed [fct_pkg::DRIVE_VEL_W-1:0] drive_velocity,
	input  logic signed [fct_pkg::TARGET_W-1:0]   joint_torque_target,
	input  logic [fct_pkg::SCALE_W-1:0]           torque_scale,
	input  logic                                  torque_negate,
	output logic                                  push,
	output fct_pkg::queue_entry_t                 entry
);
	import fct_pkg::*;

	logic signed [DRIVE_VEL_W-1:0] dbd;
	logic signed [DRIVE_VEL_W-1:0] lim;
	logic signed [DRIVE_VEL_W-1:0] neg_lim;
	logic                          above;
	logic                          below;

	assign dbd     = $signed({{(DRIVE_VEL_W - CFG_W){1'b0}}, cfg.deadband});
	assign lim     = $signed({{(DRIVE_VEL_W - CFG_W){1'b0}}, cfg.limit});
	assign neg_lim = -lim;
	assign above   = drive_velocity > dbd;
	assign below   = drive_velocity < -dbd;

	// drop requests for joints that do not exist
	assign push = start && !busy && (int'(joint_index) < JOINT_COUNT);

	always_comb begin
		entry.is_load = !mode;
		entry.joint   = joint_index;
		entry.order   = power_order;
		entry.coef    = coefficient_value;
		entry.target  = joint_torque_target;
		entry.scale   = torque_scale;
		entry.negate  = torque_negate;
		entry.active  = above || below;
		entry.side    = mode ? below : negative_side;
		if (above) begin
			entry.vel = (drive_velocity > lim) ? lim[VEL_W-1:0] : drive_velocity[VEL_W-1:0];
		end else if (below) begin
			entry.vel = (drive_velocity < neg_lim) ? neg_lim[VEL_W-1:0]
				: drive_velocity[VEL_W-1:0];
		end else begin
			entry.vel = '0;
		end
	end

endmodule

>>> design/fct_queue.sv
// Short FIFO between the intake and the compute pipeline.
module fct_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  fct_pkg::queue_entry_t push_data,
	output logic                  full,
	input  logic                  pop,
	output fct_pkg::queue_entry_t head,
	output logic                  head_valid
);
	import fct_pkg::*;

	queue_entry_t       slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = count_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> design/fct_back.sv
// Compute pipeline: coefficient tables, cubic friction terms, scaling and saturation.
module fct_back #(
	parameter int JOINT_COUNT = 6
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fct_pkg::queue_entry_t              head,
	input  logic                               head_valid,
	output logic                               pop,
	output logic                               done,
	output logic [fct_pkg::JOINT_W-1:0]        joint_echo,
	output logic signed [fct_pkg::CMD_OUT_W-1:0] torque_command,
	output logic                               command_saturated
);
	import fct_pkg::*;

	localparam int DEPTH = JOINT_COUNT * 2;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [AW-1:0]     addr;
	logic              issue;
	logic [COEF_W-1:0] coef_rd [TERM_COUNT];

	// one request leaves the queue per cycle; loads write, computes read
	assign pop   = head_valid;
	assign issue = head_valid && !head.is_load;
	assign addr  = AW'({head.joint, head.side});

	for (genvar k = 0; k < TERM_COUNT; k++) begin : g_ram
		fct_ram #(
			.WIDTH(COEF_W),
			.DEPTH(DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (head_valid && head.is_load && (head.order == ORDER_W'(k))),
			.waddr(addr),
			.wdata(head.coef),
			.raddr(addr),
			.rdata(coef_rd[k])
		);
	end

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic valid_s9;
	logic [JOINT_W-1:0] joint_s1, joint_s2, joint_s3, joint_s4, joint_s5, joint_s6, joint_s7;
	logic [JOINT_W-1:0] joint_s8, joint_s9;

	logic                       active_s1, active_s2, active_s3, active_s4, active_s5;
	logic                       active_s6, active_s7;
	logic                       negate_s1, negate_s2, negate_s3, negate_s4, negate_s5;
	logic                       negate_s6, negate_s7, negate_s8;
	logic signed [VEL_W-1:0]    vel_s1, vel_s2, vel_s3, vel_s4, vel_s5;
	logic signed [TARGET_W-1:0] target_s1;
	logic [SCALE_W-1:0]         scale_s1;
	logic signed [PRODT_W-1:0]  prod_s2, prod_s3, prod_s4, prod_s5, prod_s6, prod_s7, prod_s8;
	logic signed [COEF_W-1:0]   c0_s2, c0_s3, c0_s4, c0_s5, c0_s6, c0_s7;

	logic signed [LO_W-1:0]     lo_s2 [3];
	logic signed [HI_W-1:0]     hi_s2 [3];
	logic signed [P_W-1:0]      p1_s3 [3];
	logic signed [LO_W-1:0]     lo_s4 [2];
	logic signed [HI_W-1:0]     hi_s4 [2];
	logic signed [P_W-1:0]      p2_s5 [2];
	logic signed [LO_W-1:0]     lo_s6;
	logic signed [HI_W-1:0]     hi_s6;
	logic signed [P_W-1:0]      t1_s4, t1_s5, t1_s6, t1_s7;
	logic signed [P_W-1:0]      t2_s6, t2_s7;
	logic signed [P_W-1:0]      t3_s7;
	logic signed [FRIC_W-1:0]   fric_s8;
	logic signed [TOT_W-1:0]    total_s9;

	logic signed [TOT_W-1:0]    fric_wide;
	logic signed [CMD_W-1:0]    cmd_wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
			valid_s9 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
			valid_s9 <= valid_s8;
			done     <= valid_s9;
		end
	end

	// first multiply step of terms one to three, and target times scale
	always_ff @(posedge clk) begin
		joint_s1  <= head.joint;
		active_s1 <= head.active;
		negate_s1 <= head.negate;
		vel_s1    <= head.vel;
		target_s1 <= head.target;
		scale_s1  <= head.scale;

		joint_s2  <= joint_s1;
		active_s2 <= active_s1;
		negate_s2 <= negate_s1;
		vel_s2    <= vel_s1;
		c0_s2     <= $signed(coef_rd[0]);
		prod_s2   <= PRODT_W'(target_s1) * PRODT_W'($signed({1'b0, scale_s1}));
		for (int i = 0; i < 3; i++) begin
			lo_s2[i] <= step_lo(P_W'($signed(coef_rd[i + 1])), vel_s1);
			hi_s2[i] <= step_hi(P_W'($signed(coef_rd[i + 1])), vel_s1);
		end

		joint_s3  <= joint_s2;
		active_s3 <= active_s2;
		negate_s3 <= negate_s2;
		vel_s3    <= vel_s2;
		c0_s3     <= c0_s2;
		prod_s3   <= prod_s2;
		for (int i = 0; i < 3; i++) begin
			p1_s3[i] <= step_join(hi_s2[i], lo_s2[i]);
		end

		// second step of terms two and three
		joint_s4  <= joint_s3;
		active_s4 <= active_s3;
		negate_s4 <= negate_s3;
		vel_s4    <= vel_s3;
		c0_s4     <= c0_s3;
		prod_s4   <= prod_s3;
		t1_s4     <= p1_s3[0];
		for (int i = 0; i < 2; i++) begin
			lo_s4[i] <= step_lo(p1_s3[i + 1], vel_s3);
			hi_s4[i] <= step_hi(p1_s3[i + 1], vel_s3);
		end

		joint_s5  <= joint_s4;
		active_s5 <= active_s4;
		negate_s5 <= negate_s4;
		vel_s5    <= vel_s4;
		c0_s5     <= c0_s4;
		prod_s5   <= prod_s4;
		t1_s5     <= t1_s4;
		for (int i = 0; i < 2; i++) begin
			p2_s5[i] <= step_join(hi_s4[i], lo_s4[i]);
		end

		// third step of term three
		joint_s6  <= joint_s5;
		active_s6 <= active_s5;
		negate_s6 <= negate_s5;
		c0_s6     <= c0_s5;
		prod_s6   <= prod_s5;
		t1_s6     <= t1_s5;
		t2_s6     <= p2_s5[0];
		lo_s6     <= step_lo(p2_s5[1], vel_s5);
		hi_s6     <= step_hi(p2_s5[1], vel_s5);

		joint_s7  <= joint_s6;
		active_s7 <= active_s6;
		negate_s7 <= negate_s6;
		c0_s7     <= c0_s6;
		prod_s7   <= prod_s6;
		t1_s7     <= t1_s6;
		t2_s7     <= t2_s6;
		t3_s7     <= step_join(hi_s6, lo_s6);

		// zero friction inside the deadband
		joint_s8  <= joint_s7;
		negate_s8 <= negate_s7;
		prod_s8   <= prod_s7;
		fric_s8   <= active_s7 ? (FRIC_W'(c0_s7) + FRIC_W'(t1_s7) + FRIC_W'(t2_s7)
			+ FRIC_W'(t3_s7)) : '0;

		joint_s9  <= joint_s8;
		total_s9  <= negate_s8 ? (fric_wide + TOT_W'(prod_s8)) : (fric_wide - TOT_W'(prod_s8));

		joint_echo <= joint_s9;
		if (cmd_wide > CMD_W'(CMD_MAX)) begin
			torque_command    <= CMD_MAX;
			command_saturated <= 1'b1;
		end else if (cmd_wide < CMD_W'(CMD_MIN)) begin
			torque_command    <= CMD_MIN;
			command_saturated <= 1'b1;
		end else begin
			torque_command    <= cmd_wide[CMD_OUT_W-1:0];
			command_saturated <= 1'b0;
		end
	end

	assign fric_wide = TOT_W'(fric_s8) <<< FRIC_SHIFT;

	// truncate toward zero to whole per-mille
	always_comb begin
		logic signed [TOT_W-1:0] biased;
		biased   = total_s9 + ((total_s9 < 0) ? CMD_BIAS : '0);
		cmd_wide = CMD_W'(biased >>> CMD_SHIFT);
	end

endmodule

>>> design/friction_compensated_torque_command.sv
// Top level of the friction-compensated torque command block.
//
//  channel   handshake                 payload
//  -------   ------------------------  ------------------------------------------------
//  request   start / busy              mode joint_index negative_side power_order
//                                      coefficient_value drive_velocity
//                                      joint_torque_target torque_scale torque_negate
//  result    done (one-cycle strobe)   joint_echo torque_command command_saturated
//  config    cfg_valid / cfg_ready     cfg_index cfg_data
//
// One request is taken per cycle. A compute request passes through the queue register,
// a table read, then three chained multiply steps of two stages each, the friction sum,
// the scaled total and the final saturation before its result appears.
// Loads write the coefficient tables in order with computes; they give no result.
// Results cannot be held off, so the pipeline never stalls and busy stays low.
// Reset empties the queue, clears the pipeline valids and sets the configuration registers
// to their reset values; the coefficient tables are not cleared and must be loaded before use.
module friction_compensated_torque_command #(
	parameter int JOINT_COUNT = 6
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic                                   mode,
	input  logic [fct_pkg::JOINT_W-1:0]            joint_index,
	input  logic                                   negative_side,
	input  logic [fct_pkg::ORDER_W-1:0]            power_order,
	input  logic signed [fct_pkg::COEF_W-1:0]      coefficient_value,
	input  logic signed [fct_pkg::DRIVE_VEL_W-1:0] drive_velocity,
	input  logic signed [fct_pkg::TARGET_W-1:0]    joint_torque_target,
	input  logic [fct_pkg::SCALE_W-1:0]            torque_scale,
	input  logic                                   torque_negate,
	output logic                                   done,
	output logic [fct_pkg::JOINT_W-1:0]            joint_echo,
	output logic signed [fct_pkg::CMD_OUT_W-1:0]   torque_command,
	output logic                                   command_saturated,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [fct_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [fct_pkg::CFG_W-1:0]              cfg_data
);
	import fct_pkg::*;

	cfg_t         cfg_q;
	logic         push;
	queue_entry_t entry;
	queue_entry_t head;
	logic         head_valid;
	logic         pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadband <= DEADBAND_RESET;
			cfg_q.limit    <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DEADBAND: cfg_q.deadband <= cfg_data;
				REG_LIMIT:    cfg_q.limit    <= cfg_data;
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	fct_front #(
		.JOINT_COUNT(JOINT_COUNT)
	) u_front (
		.start              (start),
		.busy               (busy),
		.cfg                (cfg_q),
		.mode               (mode),
		.joint_index        (joint_index),
		.negative_side      (negative_side),
		.power_order        (power_order),
		.coefficient_value  (coefficient_value),
		.drive_velocity     (drive_velocity),
		.joint_torque_target(joint_torque_target),
		.torque_scale       (torque_scale),
		.torque_negate      (torque_negate),
		.push               (push),
		.entry              (entry)
	);

	fct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.full      (busy),
		.pop       (pop),
		.head      (head),
		.head_valid(head_valid)
	);

	fct_back #(
		.JOINT_COUNT(JOINT_COUNT)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head             (head),
		.head_valid       (head_valid),
		.pop              (pop),
		.done             (done),
		.joint_echo       (joint_echo),
		.torque_command   (torque_command),
		.command_saturated(command_saturated)
	);

endmodule
